FILE: rtl/assert_macros.svh
// Assertion macros used by the servo controller sequencer (esc_ctrl).
// Needs a clock named aclk and an active-low reset named aresetn in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define ESC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define ESC_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

FILE: rtl/esc_pkg.sv
// Package of the encoder servo controller: widths, constants, sequencer codes
// and the command and status types between controller and datapath.
package esc_pkg;

    localparam int DIV_W   = 48;
    localparam int MUL_A_W = 41;
    localparam int MUL_B_W = 18;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int ST_W    = 5;

    localparam logic [DIV_W-1:0]   SPEED_NUM = 48'd92160000000;
    localparam logic [MUL_B_W-1:0] POS_SCALE = 18'd92160;
    localparam logic [23:0]        SPEED_MAX = 24'h7FFFFF;
    localparam logic [23:0]        SPEED_MIN = 24'h800000;

    localparam logic [1:0] OP_EDGE    = 2'd0;
    localparam logic [1:0] OP_FILTER  = 2'd1;
    localparam logic [1:0] OP_CONTROL = 2'd2;

    localparam logic [2:0] REG_TARGET = 3'd0;
    localparam logic [2:0] REG_KI     = 3'd1;
    localparam logic [2:0] REG_KP     = 3'd2;
    localparam logic [2:0] REG_KV     = 3'd3;
    localparam logic [2:0] REG_COEF   = 3'd4;
    localparam logic [2:0] REG_CPR    = 3'd5;
    localparam logic [2:0] REG_LIMIT  = 3'd6;
    localparam logic [2:0] REG_SUPPLY = 3'd7;

    localparam logic [ST_W-1:0] ST_IDLE     = 5'd0;
    localparam logic [ST_W-1:0] ST_DECODE   = 5'd1;
    localparam logic [ST_W-1:0] ST_E_MUL    = 5'd2;
    localparam logic [ST_W-1:0] ST_E_DSTART = 5'd3;
    localparam logic [ST_W-1:0] ST_E_DWAIT  = 5'd4;
    localparam logic [ST_W-1:0] ST_E_FIN    = 5'd5;
    localparam logic [ST_W-1:0] ST_F_MUL    = 5'd6;
    localparam logic [ST_W-1:0] ST_F_FIN    = 5'd7;
    localparam logic [ST_W-1:0] ST_C_PMUL   = 5'd8;
    localparam logic [ST_W-1:0] ST_C_PSTART = 5'd9;
    localparam logic [ST_W-1:0] ST_C_PWAIT  = 5'd10;
    localparam logic [ST_W-1:0] ST_C_POS    = 5'd11;
    localparam logic [ST_W-1:0] ST_C_INT    = 5'd12;
    localparam logic [ST_W-1:0] ST_C_M1     = 5'd13;
    localparam logic [ST_W-1:0] ST_C_M2     = 5'd14;
    localparam logic [ST_W-1:0] ST_C_M3     = 5'd15;
    localparam logic [ST_W-1:0] ST_C_ACC    = 5'd16;
    localparam logic [ST_W-1:0] ST_C_CLAMP  = 5'd17;
    localparam logic [ST_W-1:0] ST_C_DMUL   = 5'd18;
    localparam logic [ST_W-1:0] ST_C_DSTART = 5'd19;
    localparam logic [ST_W-1:0] ST_C_DWAIT  = 5'd20;
    localparam logic [ST_W-1:0] ST_C_OUT    = 5'd21;

    typedef struct packed {
        logic            load;
        logic [ST_W-1:0] step;
    } cmd_t;

    typedef struct packed {
        logic       div_done;
        logic       out_free;
        logic [1:0] op;
    } status_t;

endpackage

FILE: rtl/esc_divider.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on esc_pkg for the operand width.
module esc_divider (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic [esc_pkg::DIV_W-1:0] num,
    input  logic [esc_pkg::DIV_W-1:0] den,
    output logic [esc_pkg::DIV_W-1:0] quot,
    output logic                      done
);
    import esc_pkg::*;

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic [DIV_W-1:0] rem_reg, rem_next;
    logic [DIV_W-1:0] quo_reg, quo_next;
    logic [DIV_W-1:0] den_reg;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DIV_W:0]   trial;

    assign trial = {rem_reg, quo_reg[DIV_W-1]};

    always_comb begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = '0;
            quo_next  = num;
            cnt_next  = CNT_W'(DIV_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (trial >= {1'b0, den_reg}) begin
                rem_next = DIV_W'(trial - {1'b0, den_reg});
                quo_next = {quo_reg[DIV_W-2:0], 1'b1};
            end else begin
                rem_next = trial[DIV_W-1:0];
                quo_next = {quo_reg[DIV_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (start) begin
            den_reg <= den;
        end
    end

    assign quot = quo_reg;
    assign done = done_reg;

endmodule

FILE: rtl/esc_ctrl.sv
// Sequencer of the servo controller: steps each request through the datapath.
// Depends on esc_pkg and assert_macros.svh.
`include "assert_macros.svh"
module esc_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  esc_pkg::status_t status,
    output esc_pkg::cmd_t    cmd
);
    import esc_pkg::*;

    logic [ST_W-1:0] state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:     if (s_tvalid) state_next = ST_DECODE;
            ST_DECODE: begin
                case (status.op)
                    OP_EDGE:    state_next = ST_E_MUL;
                    OP_FILTER:  state_next = ST_F_MUL;
                    OP_CONTROL: state_next = ST_C_PMUL;
                    default:    state_next = ST_IDLE;
                endcase
            end
            ST_E_MUL:    state_next = ST_E_DSTART;
            ST_E_DSTART: state_next = ST_E_DWAIT;
            ST_E_DWAIT:  if (status.div_done) state_next = ST_E_FIN;
            ST_E_FIN:    state_next = ST_IDLE;
            ST_F_MUL:    state_next = ST_F_FIN;
            ST_F_FIN:    state_next = ST_IDLE;
            ST_C_PMUL:   state_next = ST_C_PSTART;
            ST_C_PSTART: state_next = ST_C_PWAIT;
            ST_C_PWAIT:  if (status.div_done) state_next = ST_C_POS;
            ST_C_POS:    state_next = ST_C_INT;
            ST_C_INT:    state_next = ST_C_M1;
            ST_C_M1:     state_next = ST_C_M2;
            ST_C_M2:     state_next = ST_C_M3;
            ST_C_M3:     state_next = ST_C_ACC;
            ST_C_ACC:    state_next = ST_C_CLAMP;
            ST_C_CLAMP:  state_next = ST_C_DMUL;
            ST_C_DMUL:   state_next = ST_C_DSTART;
            ST_C_DSTART: state_next = ST_C_DWAIT;
            ST_C_DWAIT:  if (status.div_done) state_next = ST_C_OUT;
            ST_C_OUT:    if (status.out_free) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign cmd.load = s_tvalid && (state_reg == ST_IDLE);
    assign cmd.step = state_reg;

    `ESC_ASSERT(a_load_decode, cmd.load |=> state_reg == ST_DECODE, "request not decoded")
    `ESC_ASSERT(a_done_in_wait, status.div_done |-> (state_reg == ST_E_DWAIT ||
        state_reg == ST_C_PWAIT || state_reg == ST_C_DWAIT), "divider result unexpected")
    `ESC_ASSERT(a_out_leaves, (state_reg == ST_C_OUT && status.out_free) |=>
        state_reg == ST_IDLE, "result slot free but sequencer stuck")
    `ESC_ASSERT_ALWAYS(a_reset_idle, !aresetn |=> state_reg == ST_IDLE,
        "sequencer not idle after reset")

endmodule

FILE: rtl/esc_datapath.sv
// Datapath of the servo controller: registers, shared multiplier, divider and
// the result register. Depends on esc_pkg and esc_divider.
module esc_datapath #(
    parameter int unsigned DUTY_FULL_SCALE = 1024
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  esc_pkg::cmd_t    cmd,
    output esc_pkg::status_t status,
    input  logic [1:0]       s_tuser,
    input  logic [39:0]      s_tdata,
    input  logic             cfg_we,
    input  logic [2:0]       cfg_index,
    input  logic [23:0]      cfg_data,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [87:0]      m_tdata
);
    import esc_pkg::*;

    localparam logic [10:0]        FULL_FIELD = 11'(DUTY_FULL_SCALE);
    localparam logic [MUL_B_W-1:0] FULL_MUL   = MUL_B_W'(DUTY_FULL_SCALE);

    logic [23:0] target_reg;
    logic [15:0] ki_reg, kp_reg, kv_reg, coef_reg, cpr_reg, lim_reg, vsup_reg;

    logic [1:0]  op_reg;
    logic [31:0] time_reg;
    logic        dir_reg;

    logic [31:0] last_time_reg, last_time_next;
    logic [31:0] cnt_reg, cnt_next;
    logic [23:0] spd1_reg, spd1_next, spd2_reg, spd2_next;
    logic [23:0] med_reg, med_next, smooth_reg, smooth_next;
    logic [39:0] ei_reg, ei_next;

    logic signed [PROD_W-1:0] prod_reg, acc_reg, acc_next;
    logic [23:0]              pos_reg, pos_next;
    logic [15:0]              u_reg, u_next;

    logic        out_valid_reg;
    logic [87:0] out_data_reg;

    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic                      mul_en;
    logic [15:0]               cpr_eff, v_eff;
    logic [31:0]               period;

    logic             div_start, div_done;
    logic [DIV_W-1:0] div_num, div_den, div_quot;

    logic        out_free, out_load;
    logic [23:0] mag, speed;
    logic signed [25:0] f_sum;
    logic signed [41:0] i_sum;
    logic signed [PROD_W-1:0] sh, lim_w, t1;
    logic signed [17:0] dnum;
    logic [10:0] duty;

    function automatic logic [23:0] mid3(input logic [23:0] a, input logic [23:0] b,
                                         input logic [23:0] c);
        logic [23:0] lo, hi, m;
        lo = ($signed(a) < $signed(b)) ? a : b;
        hi = ($signed(a) < $signed(b)) ? b : a;
        m  = ($signed(hi) < $signed(c)) ? hi : c;
        return ($signed(lo) > $signed(m)) ? lo : m;
    endfunction

    assign cpr_eff = (cpr_reg == '0) ? 16'd1 : cpr_reg;
    assign v_eff   = (vsup_reg == '0) ? 16'd1 : vsup_reg;
    assign period  = time_reg - last_time_reg;

    always_comb begin
        mul_a  = '0;
        mul_b  = '0;
        mul_en = 1'b1;
        dnum   = '0;
        case (cmd.step)
            ST_E_MUL: begin
                mul_a = $signed(MUL_A_W'(period));
                mul_b = $signed(MUL_B_W'(cpr_eff));
            end
            ST_F_MUL: begin
                mul_a = MUL_A_W'($signed(med_reg)) - MUL_A_W'($signed(smooth_reg));
                mul_b = $signed(MUL_B_W'(coef_reg));
            end
            ST_C_PMUL: begin
                mul_a = MUL_A_W'($signed(cnt_reg));
                mul_b = $signed(POS_SCALE);
            end
            ST_C_M1: begin
                mul_a = MUL_A_W'($signed(ei_reg));
                mul_b = $signed(MUL_B_W'(ki_reg));
            end
            ST_C_M2: begin
                mul_a = MUL_A_W'($signed(pos_reg));
                mul_b = $signed(MUL_B_W'(kp_reg));
            end
            ST_C_M3: begin
                mul_a = MUL_A_W'($signed(smooth_reg));
                mul_b = $signed(MUL_B_W'(kv_reg));
            end
            ST_C_DMUL: begin
                if (u_reg[15]) begin
                    dnum = $signed(18'(v_eff)) + 18'($signed(u_reg));
                end else begin
                    dnum = $signed(18'(v_eff)) - 18'($signed(u_reg));
                end
                mul_a = (dnum > 0) ? MUL_A_W'(dnum) : '0;
                mul_b = $signed(FULL_MUL);
            end
            default: mul_en = 1'b0;
        endcase
    end

    always_comb begin
        div_start = 1'b0;
        div_num   = SPEED_NUM;
        div_den   = prod_reg[DIV_W-1:0];
        case (cmd.step)
            ST_E_DSTART: div_start = 1'b1;
            ST_C_PSTART: begin
                div_start = 1'b1;
                div_num   = prod_reg[PROD_W-1] ? DIV_W'(-prod_reg) : prod_reg[DIV_W-1:0];
                div_den   = DIV_W'(cpr_eff);
            end
            ST_C_DSTART: begin
                div_start = 1'b1;
                div_num   = prod_reg[DIV_W-1:0];
                div_den   = DIV_W'(v_eff);
            end
            default: div_start = 1'b0;
        endcase
    end

    esc_divider u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .quot    (div_quot),
        .done    (div_done)
    );

    assign out_free = !out_valid_reg || m_tready;
    assign out_load = (cmd.step == ST_C_OUT) && out_free;
    assign duty     = div_quot[10:0];

    always_comb begin
        last_time_next = last_time_reg;
        cnt_next       = cnt_reg;
        spd1_next      = spd1_reg;
        spd2_next      = spd2_reg;
        med_next       = med_reg;
        smooth_next    = smooth_reg;
        ei_next        = ei_reg;
        acc_next       = acc_reg;
        pos_next       = pos_reg;
        u_next         = u_reg;
        mag   = ((prod_reg == '0) || (div_quot >= DIV_W'(SPEED_MAX))) ? SPEED_MAX
                                                                      : div_quot[23:0];
        speed = dir_reg ? mag : 24'(-mag);
        f_sum = 26'($signed(smooth_reg)) + 26'(prod_reg >>> 16);
        i_sum = 42'($signed(ei_reg)) + 42'($signed(target_reg)) - 42'($signed(pos_reg));
        sh    = acc_reg >>> 12;
        lim_w = $signed(PROD_W'(lim_reg));
        t1    = sh;
        case (cmd.step)
            ST_E_FIN: begin
                last_time_next = time_reg;
                cnt_next       = dir_reg ? cnt_reg + 32'd1 : cnt_reg - 32'd1;
                med_next       = mid3(speed, spd1_reg, spd2_reg);
                spd2_next      = spd1_reg;
                spd1_next      = speed;
            end
            ST_F_FIN: begin
                if (f_sum > 26'sd8388607) begin
                    smooth_next = SPEED_MAX;
                end else if (f_sum < -26'sd8388608) begin
                    smooth_next = SPEED_MIN;
                end else begin
                    smooth_next = f_sum[23:0];
                end
            end
            ST_C_POS: begin
                if (!prod_reg[PROD_W-1]) begin
                    pos_next = (div_quot > DIV_W'(SPEED_MAX)) ? SPEED_MAX : div_quot[23:0];
                end else begin
                    pos_next = (div_quot > DIV_W'(SPEED_MIN)) ? SPEED_MIN
                                                                : 24'(-div_quot[23:0]);
                end
            end
            ST_C_INT: begin
                if (i_sum > 42'sd549755813887) begin
                    ei_next = 40'h7FFFFFFFFF;
                end else if (i_sum < -42'sd549755813888) begin
                    ei_next = 40'h8000000000;
                end else begin
                    ei_next = i_sum[39:0];
                end
            end
            ST_C_M2:  acc_next = prod_reg;
            ST_C_M3:  acc_next = acc_reg - prod_reg;
            ST_C_ACC: acc_next = acc_reg - prod_reg;
            ST_C_CLAMP: begin
                if (sh > lim_w) begin
                    t1 = lim_w;
                end else if (sh < -lim_w) begin
                    t1 = -lim_w;
                end
                if (t1 > 32767) begin
                    u_next = 16'h7FFF;
                end else if (t1 < -32768) begin
                    u_next = 16'h8000;
                end else begin
                    u_next = t1[15:0];
                end
            end
            default: u_next = u_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_reg    <= 24'd25600;
            ki_reg        <= 16'd2222;
            kp_reg        <= 16'd9883;
            kv_reg        <= 16'd1940;
            coef_reg      <= 16'd13107;
            cpr_reg       <= 16'd1280;
            lim_reg       <= 16'd12288;
            vsup_reg      <= 16'd20480;
            last_time_reg <= '0;
            cnt_reg       <= '0;
            spd1_reg      <= '0;
            spd2_reg      <= '0;
            med_reg       <= '0;
            smooth_reg    <= '0;
            ei_reg        <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_TARGET: target_reg <= cfg_data;
                    REG_KI:     ki_reg     <= cfg_data[15:0];
                    REG_KP:     kp_reg     <= cfg_data[15:0];
                    REG_KV:     kv_reg     <= cfg_data[15:0];
                    REG_COEF:   coef_reg   <= cfg_data[15:0];
                    REG_CPR:    cpr_reg    <= cfg_data[15:0];
                    REG_LIMIT:  lim_reg    <= cfg_data[15:0];
                    REG_SUPPLY: vsup_reg   <= cfg_data[15:0];
                    default:    target_reg <= target_reg;
                endcase
            end
            last_time_reg <= last_time_next;
            cnt_reg       <= cnt_next;
            spd1_reg      <= spd1_next;
            spd2_reg      <= spd2_next;
            med_reg       <= med_next;
            smooth_reg    <= smooth_next;
            ei_reg        <= ei_next;
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg   <= s_tuser;
            time_reg <= s_tdata[31:0];
            dir_reg  <= s_tdata[32];
        end
        if (mul_en) begin
            prod_reg <= mul_a * mul_b;
        end
        acc_reg <= acc_next;
        pos_reg <= pos_next;
        u_reg   <= u_next;
        if (out_load) begin
            out_data_reg <= {2'b00, smooth_reg, pos_reg, u_reg,
                             u_reg[15] ? FULL_FIELD : duty,
                             u_reg[15] ? duty : FULL_FIELD};
        end
    end

    assign status.div_done = div_done;
    assign status.out_free = out_free;
    assign status.op       = op_reg;
    assign m_tvalid        = out_valid_reg;
    assign m_tdata         = out_data_reg;

endmodule

FILE: rtl/encoder_servo_controller.sv
// Top level of the encoder servo controller: sequencer plus datapath.
// Depends on esc_pkg, esc_ctrl, esc_datapath and esc_divider.
//
//   Channel   Direction   Contents
//   s_        in          operation in tuser; edge time and direction in tdata
//   m_        out         duties, drive value, position, filtered speed
//   cfg_      in          register writes, one per clock
//
// An edge request makes one pass through the divider and a filter tick none;
// a control tick makes two passes, one for the position and one for the duty.
// One request is worked on at a time; s_tready is high only while idle.
// A control result waits in the output register; a stalled output holds the
// sequencer in its last step. Reset is synchronous and needs no clearing pass.
module encoder_servo_controller #(
    parameter int unsigned DUTY_FULL_SCALE = 1024
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [1:0]  s_tuser,   // operation
    input  logic [39:0] s_tdata,   // edge_time_us, direction, zero fill
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [87:0] m_tdata,   // duty_forward, duty_reverse, drive_value,
                                   // position, filtered_speed, zero fill
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [23:0] cfg_data
);
    import esc_pkg::*;

    cmd_t    cmd;
    status_t status;

    esc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    esc_datapath #(
        .DUTY_FULL_SCALE (DUTY_FULL_SCALE)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for encoder_servo_controller: drives edge, filter and
// control requests, predicts every control result and compares it field by field.
// Depends on esc_pkg and the encoder_servo_controller RTL only.
`timescale 1ns / 1ps

module tb_top;
    import esc_pkg::*;

    localparam longint SPD_HI = 64'sd8388607;
    localparam longint SPD_LO = -64'sd8388608;
    localparam longint INT_HI = 64'sd549755813887;
    localparam longint INT_LO = -64'sd549755813888;
    localparam longint FULL = 1024;

    typedef struct packed {
        logic [23:0] speed;
        logic [23:0] pos;
        logic [15:0] drive;
        logic [10:0] duty_rev;
        logic [10:0] duty_fwd;
    } servo_res_t;

    typedef struct {
        logic [1:0]  op;
        logic [31:0] t;
        logic        dir;
        bit          typed;
        servo_res_t  res;
    } stim_row_t;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [1:0]  s_tuser = '0;
    logic [39:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [87:0] m_tdata;
    logic        cfg_we = 0;
    logic [2:0]  cfg_index = '0;
    logic [23:0] cfg_data = '0;

    encoder_servo_controller uut (.*);

    always #2 aclk = ~aclk;

    // Predictor state and register copies.
    longint tgt, ki, kp, kv, coef, cpr, lim, sup;
    logic [31:0] last_t, cnt;
    longint sp1, sp2, med, smooth, integ;

    servo_res_t pending_res[$];
    stim_row_t  dtab[$];
    int errors = 0;
    int hold_cycles = 0;
    logic [31:0] cur_t = 0;

    function automatic longint clip(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic logic [10:0] bridge_duty(longint num, longint v);
        longint d;
        if (num <= 0) return '0;
        d = (num * FULL) / v;
        return d[10:0];
    endfunction

    function automatic bit servo_step(input logic [1:0] op, input logic [31:0] t,
                                      input logic dir, output servo_res_t r);
        longint cpr_e, den, mag, spd, lo, hi, m, pos, acc, u, v;
        logic [31:0] period;
        r = '0;
        cpr_e = cpr == 0 ? 1 : cpr;
        if (op == OP_EDGE) begin
            period = t - last_t;
            last_t = t;
            den = longint'(period) * cpr_e;
            mag = SPD_HI;
            if (den != 0 && 64'sd92160000000 / den < SPD_HI) mag = 64'sd92160000000 / den;
            spd = dir ? mag : -mag;
            cnt = dir ? cnt + 1 : cnt - 1;
            lo = spd < sp1 ? spd : sp1;
            hi = spd < sp1 ? sp1 : spd;
            m = hi < sp2 ? hi : sp2;
            med = lo > m ? lo : m;
            sp2 = sp1;
            sp1 = spd;
            return 0;
        end
        if (op == OP_FILTER) begin
            smooth = clip(smooth + (((med - smooth) * coef) >>> 16), SPD_LO, SPD_HI);
            return 0;
        end
        if (op == OP_CONTROL) begin
            pos = clip((longint'($signed(cnt)) * 92160) / cpr_e, SPD_LO, SPD_HI);
            v = sup == 0 ? 1 : sup;
            integ = clip(integ + (tgt - pos), INT_LO, INT_HI);
            acc = integ * ki - pos * kp - smooth * kv;
            u = clip(clip(acc >>> 12, -lim, lim), -32768, 32767);
            if (u >= 0) begin
                r.duty_fwd = 11'(FULL);
                r.duty_rev = bridge_duty(v - u, v);
            end else begin
                r.duty_fwd = bridge_duty(v + u, v);
                r.duty_rev = 11'(FULL);
            end
            r.drive = u[15:0];
            r.pos = pos[23:0];
            r.speed = smooth[23:0];
            return 1;
        end
        return 0;
    endfunction

    task automatic write_reg(logic [2:0] idx, longint val);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_data <= val[23:0];
        @(posedge aclk);
        case (idx)
            REG_TARGET: tgt = longint'($signed(val[23:0]));
            REG_KI:     ki = val[15:0];
            REG_KP:     kp = val[15:0];
            REG_KV:     kv = val[15:0];
            REG_COEF:   coef = val[15:0];
            REG_CPR:    cpr = val[15:0];
            REG_LIMIT:  lim = val[15:0];
            default:    sup = val[15:0];
        endcase
    endtask

    task automatic settle();
        while (pending_res.size() != 0) @(posedge aclk);
        repeat (130) @(posedge aclk);
    endtask

    // Sends one request; the gap is drawn per request and valid stays high across
    // back-to-back requests.
    task automatic send_request(logic [1:0] op, logic [31:0] t, logic dir, bit typed,
                                servo_res_t typed_res);
        int gap;
        servo_res_t r;
        gap = $urandom_range(0, 10);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            s_tvalid <= 0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tuser <= op;
        s_tdata <= {7'd0, dir, t};
        do @(posedge aclk); while (!s_tready);
        if (servo_step(op, t, dir, r)) pending_res.push_back(typed ? typed_res : r);
    endtask

    task automatic add_row(logic [1:0] op, logic [31:0] t, logic dir);
        stim_row_t row;
        row.op = op;
        row.t = t;
        row.dir = dir;
        row.typed = 0;
        row.res = '0;
        dtab.push_back(row);
    endtask

    task automatic random_request();
        int sel;
        logic [1:0] op;
        sel = $urandom_range(0, 99);
        op = sel < 50 ? OP_EDGE : sel < 70 ? OP_FILTER : sel < 95 ? OP_CONTROL : 2'd3;
        if (op == OP_EDGE) begin
            sel = $urandom_range(0, 99);
            if (sel < 8) cur_t = cur_t;
            else if (sel < 16) cur_t = $urandom;
            else if (sel < 24) cur_t = cur_t + $urandom;
            else cur_t = cur_t + $urandom_range(1, 5000);
        end
        send_request(op, op == OP_EDGE ? cur_t : $urandom,
                     op == OP_EDGE ? ($urandom_range(0, 9) < 7) : $urandom_range(0, 1),
                     0, '0);
    endtask

    // Result side: random stalls, one long hold when requested.
    initial begin
        servo_res_t got, want;
        int stall, mism;
        mism = 0;
        forever begin
            stall = hold_cycles > 0 ? hold_cycles : $urandom_range(0, 10);
            if (hold_cycles > 0) hold_cycles = 0;
            else if ($urandom_range(0, 3) == 0) stall = 0;
            if (stall > 0) begin
                m_tready <= 0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1;
            do @(posedge aclk); while (!m_tvalid);
            got = m_tdata[85:0];
            if (pending_res.size() == 0) begin
                errors++;
                if (mism++ < 10) $display("unexpected result %h", got);
            end else begin
                want = pending_res.pop_front();
                if (got.duty_fwd !== want.duty_fwd || got.duty_rev !== want.duty_rev ||
                    got.drive !== want.drive || got.pos !== want.pos ||
                    got.speed !== want.speed) begin
                    errors++;
                    if (mism++ < 10)
                        $display("mismatch: fwd %0d/%0d rev %0d/%0d drive %h/%h pos %h/%h spd %h/%h",
                                 want.duty_fwd, got.duty_fwd, want.duty_rev, got.duty_rev,
                                 want.drive, got.drive, want.pos, got.pos,
                                 want.speed, got.speed);
                end
            end
        end
    end

    initial begin
        #8ms;
        $display("encoder_servo_controller regression: fail");
        $finish;
    end

    initial begin
        stim_row_t row;
        tgt = 25600; ki = 2222; kp = 9883; kv = 1940;
        coef = 13107; cpr = 1280; lim = 12288; sup = 20480;
        last_t = 0; cnt = 0; sp1 = 0; sp2 = 0; med = 0; smooth = 0; integ = 0;
        repeat (7) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // After reset the integrator alone drives u past the limit.
        row.op = OP_CONTROL; row.t = 0; row.dir = 0; row.typed = 1;
        row.res = '{duty_fwd: 11'd1024, duty_rev: 11'd409, drive: 16'd12288,
                    pos: 24'd0, speed: 24'd0};
        dtab.push_back(row);
        add_row(2'd3, 32'hFFFFFFFF, 1);
        add_row(OP_FILTER, 0, 0);
        add_row(OP_EDGE, 32'd1000, 1);
        add_row(OP_EDGE, 32'd1000, 1);
        add_row(OP_EDGE, 32'd2000, 0);
        add_row(OP_FILTER, 0, 0);
        add_row(OP_CONTROL, 0, 0);
        add_row(OP_EDGE, 32'hFFFFFFFF, 1);
        add_row(OP_EDGE, 32'd5, 1);
        add_row(OP_EDGE, 32'hAAAAAAAA, 0);
        add_row(OP_EDGE, 32'h55555555, 1);
        add_row(OP_EDGE, 32'h55555556, 0);
        add_row(OP_FILTER, 0, 0);
        add_row(OP_FILTER, 0, 0);
        add_row(OP_CONTROL, 32'hFFFFFFFF, 1);
        add_row(2'd3, 0, 0);
        add_row(OP_CONTROL, 0, 0);
        foreach (dtab[i]) send_request(dtab[i].op, dtab[i].t, dtab[i].dir,
                                       dtab[i].typed, dtab[i].res);
        cur_t = 32'h55555556;

        for (int ph = 0; ph < 5; ph++) begin
            s_tvalid <= 0;
            settle();
            case (ph)
                0: begin
                    write_reg(REG_TARGET, 8388607); write_reg(REG_KI, 65535);
                    write_reg(REG_KP, 0);           write_reg(REG_KV, 0);
                    write_reg(REG_COEF, 65535);     write_reg(REG_CPR, 0);
                    write_reg(REG_LIMIT, 65535);    write_reg(REG_SUPPLY, 0);
                end
                1: begin
                    write_reg(REG_TARGET, -8388608); write_reg(REG_KI, 0);
                    write_reg(REG_KP, 65535);        write_reg(REG_KV, 65535);
                    write_reg(REG_COEF, 0);          write_reg(REG_CPR, 65535);
                    write_reg(REG_LIMIT, 0);         write_reg(REG_SUPPLY, 65535);
                    hold_cycles = 400;
                end
                default: begin
                    write_reg(REG_TARGET, $signed(24'($urandom)));
                    write_reg(REG_KI, $urandom_range(0, 65535));
                    write_reg(REG_KP, $urandom_range(0, 65535));
                    write_reg(REG_KV, $urandom_range(0, 65535));
                    write_reg(REG_COEF, $urandom_range(0, 65535));
                    write_reg(REG_CPR, $urandom_range(1, 4096));
                    write_reg(REG_LIMIT, $urandom_range(0, 65535));
                    write_reg(REG_SUPPLY, $urandom_range(1, 65535));
                end
            endcase
            cfg_we <= 0;
            for (int n = 0; n < 250; n++) random_request();
        end

        s_tvalid <= 0;
        fork
            while (pending_res.size() != 0) @(posedge aclk);
            repeat (100000) @(posedge aclk);
        join_any
        disable fork;
        repeat (150) @(posedge aclk);
        if (errors == 0 && pending_res.size() == 0) begin
            $display("encoder_servo_controller regression: pass");
        end else begin
            $display("encoder_servo_controller regression: fail");
        end
        $finish;
    end
endmodule

FILE: sim.f
+incdir+rtl
rtl/esc_pkg.sv
rtl/esc_divider.sv
rtl/esc_ctrl.sv
rtl/esc_datapath.sv
rtl/encoder_servo_controller.sv
tb/tb_top.sv
